FILE: rtl/fca_pkg.sv
// Shared definitions for the file allocation table chain allocator.
// Holds field widths, command and status codes, link values and the sequencer states.
// Depends on nothing; fat_chain_allocator and fca_checker in this folder import it.
package fca_pkg;

  localparam int MAX_BLOCKS_DEF        = 1024;
  localparam int ADDRS_PER_TABLE_BLOCK = 1024;

  localparam int ACTION_W = 2;
  localparam int HEAD_W   = 10;
  localparam int NUM_W    = 11;
  localparam int STATUS_W = 3;

  typedef logic [NUM_W-1:0] ptr_t;

  localparam ptr_t TOTAL_RESET = 11'd1024;

  localparam ptr_t LINK_FREE = 11'd0;
  localparam ptr_t LINK_END  = 11'd1;
  localparam ptr_t LINK_RSVD = 11'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FORMAT = 2'd0,
    ACT_EXTEND = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_SEEK   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_PARTIAL    = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_SEEK_END   = 3'd3,
    ST_WALK_LIMIT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FORMAT,
    S_WALK,
    S_WALK_WAIT,
    S_SCAN,
    S_SCAN_WAIT,
    S_TAIL,
    S_TAIL_WAIT,
    S_FREE,
    S_FREE_WAIT,
    S_SEEK,
    S_SEEK_WAIT,
    S_FINISH
  } state_t;

endpackage

FILE: rtl/fat_chain_allocator.sv
// Top level of the file allocation table chain allocator.
// Depends on fca_pkg and instantiates fca_ram for the link table.
//
// Usage:
// Commands arrive on the in_ channel (valid/ready) as action, head and count. Each
// command produces exactly one result transaction on the out_ channel (new_head,
// blocks, status). The cfg_ channel writes total_blocks and is always ready; write
// it only while no command is in flight.
// One command is processed at a time. in_ready is high while the sequencer is idle,
// which includes while a finished result waits in the output register.
// Each link table read goes through the registered read port of the single-port
// link table RAM, so every read state is followed by a wait state. Per command:
//   format: writes all MAX_BLOCKS (capped at 2048) entries, one table entry per cycle.
//   extend: walks the existing chain, scans for free entries, links them, ends the tail.
//   free:   follows the chain and releases each block in turn.
//   seek:   follows the chain one link per step, for count steps.
// A stalled receiver holds the result in the output register; the next command can
// still be accepted, but its result waits until the held one is taken.
// Reset sets total_blocks to 1024 and empties the pipeline. The table holds no
// defined contents until a format command has been processed.
module fat_chain_allocator #(
  parameter int MAX_BLOCKS = fca_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fca_pkg::NUM_W-1:0]     cfg_total_blocks,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fca_pkg::ACTION_W-1:0]  in_action,
  input  logic [fca_pkg::HEAD_W-1:0]    in_head,
  input  logic [fca_pkg::NUM_W-1:0]     in_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fca_pkg::HEAD_W-1:0]    out_new_head,
  output logic [fca_pkg::NUM_W-1:0]     out_blocks,
  output logic [fca_pkg::STATUS_W-1:0]  out_status
);
  import fca_pkg::*;

  localparam int NCAP    = (MAX_BLOCKS < 2047) ? MAX_BLOCKS : 2047;
  localparam int DEPTH   = (MAX_BLOCKS < 2048) ? MAX_BLOCKS : 2048;
  localparam int AW      = $clog2(DEPTH);
  localparam int SUM_W0  = $clog2(NCAP + ADDRS_PER_TABLE_BLOCK) + 1;
  localparam int SUM_W   = (SUM_W0 > NUM_W) ? SUM_W0 : NUM_W + 1;

  state_t              state_r, state_nxt;
  ptr_t                total_r, total_r_nxt;
  action_t             action_r, action_r_nxt;
  logic [HEAD_W-1:0]   head_r, head_r_nxt;
  ptr_t                count_r, count_r_nxt;
  ptr_t                hreg_r, hreg_r_nxt;
  ptr_t                loc_r, loc_r_nxt;
  ptr_t                found_r, found_r_nxt;
  ptr_t                scan_r, scan_r_nxt;
  ptr_t                rsv_r, rsv_r_nxt;
  logic                on_head_r, on_head_r_nxt;
  status_t             status_r, status_r_nxt;
  logic [AW-1:0]       fmt_idx_r, fmt_idx_r_nxt;

  logic                out_valid_r, out_valid_r_nxt;
  logic [HEAD_W-1:0]   out_new_head_r, out_new_head_r_nxt;
  ptr_t                out_blocks_r, out_blocks_r_nxt;
  status_t             out_status_r, out_status_r_nxt;

  ptr_t                n_eff;
  logic [SUM_W-1:0]    rsv_sum;
  logic [SUM_W-1:0]    rsv_full;
  ptr_t                rsv_calc;

  logic                mem_en;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [AW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_rdata;
  ptr_t                rd_v;

  logic                walk_go;
  ptr_t                walk_v;

  fca_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_link_table (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign rd_v      = ptr_t'(mem_rdata);
  assign n_eff     = (total_r > ptr_t'(NCAP)) ? ptr_t'(NCAP) : total_r;
  assign rsv_sum   = SUM_W'(n_eff) + SUM_W'(ADDRS_PER_TABLE_BLOCK - 1);
  assign rsv_full  = SUM_W'(rsv_sum / ADDRS_PER_TABLE_BLOCK) + SUM_W'(2);
  assign rsv_calc  = (rsv_full > SUM_W'(n_eff)) ? n_eff : rsv_full[NUM_W-1:0];

  assign cfg_ready    = 1'b1;
  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_new_head = out_new_head_r;
  assign out_blocks   = out_blocks_r;
  assign out_status   = out_status_r;

  always_comb begin
    state_nxt          = state_r;
    total_r_nxt        = total_r;
    action_r_nxt       = action_r;
    head_r_nxt         = head_r;
    count_r_nxt        = count_r;
    hreg_r_nxt         = hreg_r;
    loc_r_nxt          = loc_r;
    found_r_nxt        = found_r;
    scan_r_nxt         = scan_r;
    rsv_r_nxt          = rsv_r;
    on_head_r_nxt      = on_head_r;
    status_r_nxt       = status_r;
    fmt_idx_r_nxt      = fmt_idx_r;
    out_valid_r_nxt    = out_valid_r;
    out_new_head_r_nxt = out_new_head_r;
    out_blocks_r_nxt   = out_blocks_r;
    out_status_r_nxt   = out_status_r;
    mem_en             = 1'b0;
    mem_we             = 1'b0;
    mem_addr           = '0;
    mem_wdata          = '0;
    walk_go            = 1'b0;
    walk_v             = LINK_FREE;

    if (cfg_valid) begin
      total_r_nxt = cfg_total_blocks;
    end
    if (out_valid_r && out_ready) begin
      out_valid_r_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          action_r_nxt  = action_t'(in_action);
          head_r_nxt    = in_head;
          count_r_nxt   = in_count;
          hreg_r_nxt    = ptr_t'(in_head);
          loc_r_nxt     = ptr_t'(in_head);
          found_r_nxt   = '0;
          scan_r_nxt    = '0;
          on_head_r_nxt = 1'b1;
          status_r_nxt  = ST_OK;
          rsv_r_nxt     = rsv_calc;
          fmt_idx_r_nxt = '0;
          case (action_t'(in_action))
            ACT_FORMAT: state_nxt = S_FORMAT;
            ACT_EXTEND: state_nxt = S_WALK;
            ACT_FREE:   state_nxt = S_FREE;
            ACT_SEEK:   state_nxt = S_SEEK;
            default:    state_nxt = S_FINISH;
          endcase
        end
      end
      S_FORMAT: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = fmt_idx_r;
        mem_wdata = (ptr_t'(fmt_idx_r) < rsv_r) ? LINK_RSVD[AW-1:0] : LINK_FREE[AW-1:0];
        if (fmt_idx_r == AW'(DEPTH - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          fmt_idx_r_nxt = fmt_idx_r + 1'b1;
        end
      end
      S_WALK: begin
        if (found_r >= count_r) begin
          state_nxt = S_SCAN;
        end else if (on_head_r) begin
          walk_go = 1'b1;
          walk_v  = hreg_r;
        end else if (loc_r >= n_eff) begin
          walk_go = 1'b1;
          walk_v  = LINK_FREE;
        end else begin
          mem_en    = 1'b1;
          mem_addr  = loc_r[AW-1:0];
          state_nxt = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        walk_go = 1'b1;
        walk_v  = rd_v;
      end
      S_SCAN: begin
        if (found_r >= count_r || scan_r >= n_eff) begin
          state_nxt = S_TAIL;
        end else begin
          mem_en    = 1'b1;
          mem_addr  = scan_r[AW-1:0];
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_nxt  = S_SCAN;
        scan_r_nxt = scan_r + 1'b1;
        if (rd_v == LINK_FREE) begin
          if (on_head_r) begin
            hreg_r_nxt = scan_r;
          end else if (loc_r < n_eff) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = loc_r[AW-1:0];
            mem_wdata = scan_r[AW-1:0];
          end
          on_head_r_nxt = 1'b0;
          loc_r_nxt     = scan_r;
          found_r_nxt   = found_r + 1'b1;
        end
      end
      S_TAIL: begin
        state_nxt = S_FINISH;
        if (count_r != '0 && found_r == '0) begin
          status_r_nxt = ST_NO_SPACE;
        end else if (found_r < count_r) begin
          status_r_nxt = ST_PARTIAL;
        end else begin
          status_r_nxt = ST_OK;
        end
        if (on_head_r) begin
          if (hreg_r == LINK_FREE) begin
            hreg_r_nxt = LINK_END;
          end
        end else if (loc_r < n_eff) begin
          mem_en    = 1'b1;
          mem_addr  = loc_r[AW-1:0];
          state_nxt = S_TAIL_WAIT;
        end
      end
      S_TAIL_WAIT: begin
        state_nxt = S_FINISH;
        if (rd_v == LINK_FREE) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = loc_r[AW-1:0];
          mem_wdata = LINK_END[AW-1:0];
        end
      end
      S_FREE: begin
        if (loc_r == LINK_END) begin
          state_nxt = S_FINISH;
        end else if (found_r >= n_eff) begin
          status_r_nxt = ST_WALK_LIMIT;
          state_nxt    = S_FINISH;
        end else if (loc_r >= n_eff) begin
          loc_r_nxt   = LINK_FREE;
          found_r_nxt = found_r + 1'b1;
        end else begin
          mem_en    = 1'b1;
          mem_addr  = loc_r[AW-1:0];
          state_nxt = S_FREE_WAIT;
        end
      end
      S_FREE_WAIT: begin
        mem_en      = 1'b1;
        mem_we      = 1'b1;
        mem_addr    = loc_r[AW-1:0];
        mem_wdata   = LINK_FREE[AW-1:0];
        loc_r_nxt   = rd_v;
        found_r_nxt = found_r + 1'b1;
        state_nxt   = S_FREE;
      end
      S_SEEK: begin
        if (found_r >= count_r) begin
          state_nxt = S_FINISH;
        end else if (loc_r == LINK_END) begin
          status_r_nxt = ST_SEEK_END;
          state_nxt    = S_FINISH;
        end else if (found_r >= n_eff) begin
          status_r_nxt = ST_WALK_LIMIT;
          state_nxt    = S_FINISH;
        end else if (loc_r >= n_eff) begin
          loc_r_nxt   = LINK_FREE;
          found_r_nxt = found_r + 1'b1;
        end else begin
          mem_en    = 1'b1;
          mem_addr  = loc_r[AW-1:0];
          state_nxt = S_SEEK_WAIT;
        end
      end
      S_SEEK_WAIT: begin
        loc_r_nxt   = rd_v;
        found_r_nxt = found_r + 1'b1;
        state_nxt   = S_SEEK;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_r_nxt  = 1'b1;
          out_status_r_nxt = status_r;
          state_nxt        = S_IDLE;
          case (action_r)
            ACT_FORMAT: begin
              out_new_head_r_nxt = head_r;
              out_blocks_r_nxt   = '0;
            end
            ACT_EXTEND: begin
              out_new_head_r_nxt = hreg_r[HEAD_W-1:0];
              out_blocks_r_nxt   = found_r;
            end
            ACT_FREE: begin
              out_new_head_r_nxt = head_r;
              out_blocks_r_nxt   = found_r;
            end
            ACT_SEEK: begin
              out_new_head_r_nxt = loc_r[HEAD_W-1:0];
              out_blocks_r_nxt   = '0;
            end
            default: begin
              out_new_head_r_nxt = head_r;
              out_blocks_r_nxt   = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (walk_go) begin
      if (walk_v == LINK_END) begin
        state_nxt = S_SCAN;
      end else if (found_r >= n_eff) begin
        status_r_nxt = ST_WALK_LIMIT;
        state_nxt    = S_FINISH;
      end else begin
        on_head_r_nxt = 1'b0;
        loc_r_nxt     = walk_v;
        found_r_nxt   = found_r + 1'b1;
        state_nxt     = S_WALK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= TOTAL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_r_nxt;
      out_valid_r <= out_valid_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r       <= action_r_nxt;
    head_r         <= head_r_nxt;
    count_r        <= count_r_nxt;
    hreg_r         <= hreg_r_nxt;
    loc_r          <= loc_r_nxt;
    found_r        <= found_r_nxt;
    scan_r         <= scan_r_nxt;
    rsv_r          <= rsv_r_nxt;
    on_head_r      <= on_head_r_nxt;
    status_r       <= status_r_nxt;
    fmt_idx_r      <= fmt_idx_r_nxt;
    out_new_head_r <= out_new_head_r_nxt;
    out_blocks_r   <= out_blocks_r_nxt;
    out_status_r   <= out_status_r_nxt;
  end

endmodule

FILE: rtl/fca_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Used for the link table of the chain allocator; depends on no package.
module fca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/fca_checker.sv
// Port-level checker for the chain allocator, attached to the top level by a bind.
// Depends on fca_pkg for the status codes.
module fca_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fca_pkg::HEAD_W-1:0]    out_new_head,
  input logic [fca_pkg::NUM_W-1:0]     out_blocks,
  input logic [fca_pkg::STATUS_W-1:0]  out_status
);
  import fca_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_PARTIAL ||
                   out_status == ST_NO_SPACE || out_status == ST_SEEK_END ||
                   out_status == ST_WALK_LIMIT))
    else $error("Result transaction carries an undefined status code.");

  a_no_space_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_NO_SPACE) |-> (out_blocks == '0))
    else $error("A failed allocation reports a nonzero block count.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !$rose(out_valid)))
    else $error("Command transaction did not occupy the sequencer.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_new_head) &&
                                   $stable(out_blocks) && $stable(out_status)))
    else $error("Stalled result transaction changed or was dropped.");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_new_head (out_new_head),
  .out_blocks   (out_blocks),
  .out_status   (out_status)
);

FILE: test/fat_chain_allocator_checker.sv
`timescale 1ns / 1ps
// Checker for the chain allocator: watches the config, command and result channels.
// It keeps its own link table and block count, predicts every result and compares.
// Depends on fca_pkg; instantiated by fat_chain_allocator_test beside the block.
module fat_chain_allocator_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fca_pkg::NUM_W-1:0]     cfg_total_blocks,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [fca_pkg::ACTION_W-1:0]  in_action,
  input  logic [fca_pkg::HEAD_W-1:0]    in_head,
  input  logic [fca_pkg::NUM_W-1:0]     in_count,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [fca_pkg::HEAD_W-1:0]    out_new_head,
  input  logic [fca_pkg::NUM_W-1:0]     out_blocks,
  input  logic [fca_pkg::STATUS_W-1:0]  out_status,
  output int                            mismatches,
  output int                            results_due
);
  import fca_pkg::*;

  typedef struct packed {
    logic [HEAD_W-1:0] new_head;
    logic [NUM_W-1:0]  blocks;
    status_t           status;
  } chain_result_t;

  logic [HEAD_W-1:0] link_tbl [MAX_BLOCKS_DEF];
  logic [NUM_W-1:0]  block_total;
  chain_result_t     awaited_results [$];

  function automatic logic [HEAD_W-1:0] link_at(input logic [HEAD_W-1:0] idx,
                                                input int unsigned n);
    return (idx < n) ? link_tbl[idx] : '0;
  endfunction

  function automatic void set_link(input logic [HEAD_W-1:0] idx,
                                   input logic [HEAD_W-1:0] val,
                                   input int unsigned n);
    if (idx < n) link_tbl[idx] = val;
  endfunction

  function automatic chain_result_t apply_command(input action_t act,
                                                  input logic [HEAD_W-1:0] head,
                                                  input logic [NUM_W-1:0] cnt);
    chain_result_t     res;
    int unsigned       n, rsv, found, scan, i, released, step;
    logic [HEAD_W-1:0] hreg, loc, v, cur, idx, nxt;
    bit                on_head, limit;
    n = (block_total > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : block_total;
    res.new_head = head;
    res.blocks = '0;
    res.status = ST_OK;
    case (act)
      ACT_FORMAT: begin
        rsv = 2 + (n + ADDRS_PER_TABLE_BLOCK - 1) / ADDRS_PER_TABLE_BLOCK;
        if (rsv > n) rsv = n;
        for (i = 0; i < MAX_BLOCKS_DEF; i++)
          link_tbl[i] = (i < rsv) ? LINK_RSVD[HEAD_W-1:0] : LINK_FREE[HEAD_W-1:0];
      end
      ACT_EXTEND: begin
        hreg = head;
        loc = '0;
        found = 0;
        on_head = 1'b1;
        limit = 1'b0;
        while (found < cnt) begin
          v = on_head ? hreg : link_at(loc, n);
          if (v == LINK_END) break;
          if (found >= n) begin
            limit = 1'b1;
            break;
          end
          on_head = 1'b0;
          loc = v;
          found++;
        end
        if (!limit) begin
          scan = 0;
          while (found < cnt) begin
            i = scan;
            while (i < n && link_tbl[i] != LINK_FREE) i++;
            if (i >= n) break;
            if (on_head) hreg = i[HEAD_W-1:0];
            else set_link(loc, i[HEAD_W-1:0], n);
            on_head = 1'b0;
            loc = i[HEAD_W-1:0];
            found++;
            scan = i + 1;
          end
          v = on_head ? hreg : link_at(loc, n);
          if (v == LINK_FREE) begin
            if (on_head) hreg = LINK_END[HEAD_W-1:0];
            else set_link(loc, LINK_END[HEAD_W-1:0], n);
          end
          if (cnt > 0 && found == 0) res.status = ST_NO_SPACE;
          else if (found < cnt) res.status = ST_PARTIAL;
        end else begin
          res.status = ST_WALK_LIMIT;
        end
        res.new_head = hreg;
        res.blocks = found[NUM_W-1:0];
      end
      ACT_FREE: begin
        idx = head;
        released = 0;
        while (idx != LINK_END) begin
          if (released >= n) begin
            res.status = ST_WALK_LIMIT;
            break;
          end
          nxt = link_at(idx, n);
          set_link(idx, LINK_FREE[HEAD_W-1:0], n);
          idx = nxt;
          released++;
        end
        res.blocks = released[NUM_W-1:0];
      end
      default: begin
        cur = head;
        for (step = 0; step < cnt; step++) begin
          if (cur == LINK_END) begin
            res.status = ST_SEEK_END;
            break;
          end
          if (step >= n) begin
            res.status = ST_WALK_LIMIT;
            break;
          end
          cur = link_at(cur, n);
        end
        res.new_head = cur;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    chain_result_t want;
    if (!rst_n) begin
      block_total = TOTAL_RESET;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: head %0d blocks %0d status %0d",
                   $time, out_new_head, out_blocks, out_status);
        end else begin
          want = awaited_results.pop_front();
          if (out_new_head !== want.new_head || out_blocks !== want.blocks ||
              out_status !== want.status) begin
            mismatches++;
            $display("%0t: expected head %0d blocks %0d status %0d, got head %0d blocks %0d status %0d",
                     $time, want.new_head, want.blocks, want.status,
                     out_new_head, out_blocks, out_status);
          end
        end
      end
      if (cfg_valid && cfg_ready) block_total = cfg_total_blocks;
      if (in_valid && in_ready)
        awaited_results.push_back(apply_command(action_t'(in_action), in_head, in_count));
    end
    results_due = awaited_results.size();
  end

endmodule

FILE: test/fat_chain_allocator_test.sv
`timescale 1ns / 1ps
// Top of the chain allocator testbench: clock, reset, command and config stimulus.
// Depends on fca_pkg, fat_chain_allocator and fat_chain_allocator_checker.
module fat_chain_allocator_test;
  import fca_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 100;
  localparam logic [HEAD_W-1:0] EMPTY_CHAIN = LINK_END[HEAD_W-1:0];

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [NUM_W-1:0]    cfg_total_blocks = TOTAL_RESET;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action = ACT_FORMAT;
  logic [HEAD_W-1:0]   in_head = '0;
  logic [NUM_W-1:0]    in_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [HEAD_W-1:0]   out_new_head;
  logic [NUM_W-1:0]    out_blocks;
  logic [STATUS_W-1:0] out_status;

  int mismatches;
  int results_due;
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int sizes_used = 0;
  int cmd_total [4] = '{0, 0, 0, 0};

  logic [HEAD_W-1:0] chain_heads [$];
  action_t           sent_actions [$];

  fat_chain_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_total_blocks (cfg_total_blocks),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_head          (in_head),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_head     (out_new_head),
    .out_blocks       (out_blocks),
    .out_status       (out_status)
  );

  fat_chain_allocator_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_total_blocks (cfg_total_blocks),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_head          (in_head),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_head     (out_new_head),
    .out_blocks       (out_blocks),
    .out_status       (out_status),
    .mismatches       (mismatches),
    .results_due      (results_due)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver process; a requested hold-off keeps out_ready low for a long stretch.
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Chains created by extend transactions become targets for later commands.
  always @(posedge clk) begin : track_chains
    action_t done_act;
    bit      known;
    if (rst_n) begin
      if (out_valid && out_ready && sent_actions.size() > 0) begin
        done_act = sent_actions.pop_front();
        known = 1'b0;
        foreach (chain_heads[j])
          if (chain_heads[j] == out_new_head) known = 1'b1;
        if (done_act == ACT_EXTEND && out_status != ST_WALK_LIMIT &&
            out_new_head != EMPTY_CHAIN && !known && chain_heads.size() < 12)
          chain_heads.push_back(out_new_head);
      end
      if (in_valid && in_ready) sent_actions.push_back(action_t'(in_action));
    end
  end

  task automatic send_cmd(input action_t act, input logic [HEAD_W-1:0] head,
                          input logic [NUM_W-1:0] cnt);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_head <= head;
    in_count <= cnt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    cmd_total[act]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_total(input logic [NUM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_total_blocks <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    chain_heads.delete();
    sizes_used++;
  endtask

  task automatic random_cmd();
    int unsigned       pick;
    int                j;
    action_t           act;
    logic [HEAD_W-1:0] head;
    logic [NUM_W-1:0]  cnt;
    pick = $urandom_range(99);
    head = EMPTY_CHAIN;
    if (chain_heads.size() > 0) head = chain_heads[$urandom_range(chain_heads.size() - 1)];
    if (pick < 3) begin
      act = ACT_FORMAT;
      head = HEAD_W'($urandom);
      cnt = NUM_W'($urandom_range(1024));
      chain_heads.delete();
    end else if (pick < 43) begin
      act = ACT_EXTEND;
      if ($urandom_range(2) == 0) head = EMPTY_CHAIN;
      cnt = ($urandom_range(9) == 0) ? NUM_W'($urandom_range(1024))
                                     : NUM_W'($urandom_range(6));
    end else if (pick < 63) begin
      act = ACT_FREE;
      cnt = NUM_W'($urandom_range(1024));
      for (j = 0; j < chain_heads.size(); j++)
        if (chain_heads[j] == head) begin
          chain_heads.delete(j);
          break;
        end
    end else if (pick < 93) begin
      act = ACT_SEEK;
      cnt = NUM_W'($urandom_range(12));
    end else begin
      act = action_t'($urandom_range(3));
      head = HEAD_W'($urandom_range(1023));
      cnt = NUM_W'($urandom_range(1024));
    end
    send_cmd(act, head, cnt);
  endtask

  initial begin
    int phase;
    int k;
    int tier;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    snd_idle = 22;
    rcv_idle = 87;
    write_total(TOTAL_RESET);

    send_cmd(ACT_FORMAT, 10'd0, 11'd0);
    send_cmd(ACT_EXTEND, EMPTY_CHAIN, 11'd0);
    send_cmd(ACT_EXTEND, EMPTY_CHAIN, 11'd3);
    send_cmd(ACT_EXTEND, 10'd3, 11'd5);
    send_cmd(ACT_EXTEND, 10'd0, 11'd2);
    send_cmd(ACT_EXTEND, 10'd0, 11'd0);
    send_cmd(ACT_SEEK, 10'd3, 11'd0);
    send_cmd(ACT_SEEK, 10'd3, 11'd3);
    send_cmd(ACT_SEEK, 10'd3, 11'd5);
    send_cmd(ACT_SEEK, 10'd3, 11'd6);
    send_cmd(ACT_EXTEND, EMPTY_CHAIN, 11'd1024);
    send_cmd(ACT_EXTEND, EMPTY_CHAIN, 11'd1);
    send_cmd(ACT_EXTEND, 10'd3, 11'd7);
    send_cmd(ACT_FREE, 10'd8, 11'd0);
    send_cmd(ACT_FREE, 10'd3, 11'd0);
    send_cmd(ACT_FREE, EMPTY_CHAIN, 11'd0);
    send_cmd(ACT_SEEK, 10'd2, 11'd1024);
    send_cmd(ACT_EXTEND, 10'd2, 11'd1024);
    send_cmd(ACT_FORMAT, 10'd1023, 11'd1024);
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      tier = phase / 3;
      snd_idle = (tier == 0) ? 22 : (tier == 1) ? 87 : 0;
      rcv_idle = (tier == 0) ? 87 : (tier == 1) ? 22 : 0;
      if (phase == 0) write_total(11'd3);
      else if (phase % 3 == 2) write_total(TOTAL_RESET);
      else write_total(NUM_W'($urandom_range(4, 200)));
      if (phase == 0) begin
        send_cmd(ACT_FORMAT, 10'd0, 11'd0);
        send_cmd(ACT_EXTEND, EMPTY_CHAIN, 11'd1);
        send_cmd(ACT_SEEK, 10'd2, 11'd5);
        send_cmd(ACT_FREE, 10'd1023, 11'd0);
        send_cmd(ACT_EXTEND, 10'd1023, 11'd2);
        send_cmd(ACT_FORMAT, 10'd0, 11'd0);
      end else if (phase == 1 || $urandom_range(3) != 0) begin
        send_cmd(ACT_FORMAT, HEAD_W'($urandom), 11'd0);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ((phase == 1 || phase == 6) && k == PHASE_ITEMS / 2) hold_asked++;
        if (phase == 4 && k == PHASE_ITEMS / 2) drain_results();
        random_cmd();
      end
      drain_results();
    end

    repeat (20) @(negedge clk);
    $display("Covered %0d formats, %0d extends, %0d frees and %0d seeks over %0d table sizes,",
             cmd_total[ACT_FORMAT], cmd_total[ACT_EXTEND], cmd_total[ACT_FREE],
             cmd_total[ACT_SEEK], sizes_used);
    $display("with three idle mixes and long result stalls; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fca_pkg.sv
rtl/fca_ram.sv
rtl/fat_chain_allocator.sv
rtl/fca_checker.sv
test/fat_chain_allocator_checker.sv
test/fat_chain_allocator_test.sv
